// ----- src/stepper_step_rate_generator_assert.svh -----
// Assertion macros for the module that checks its own logic.
`ifndef STEPPER_STEP_RATE_GENERATOR_ASSERT_SVH
`define STEPPER_STEP_RATE_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define SSRG_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define SSRG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ssrg_pkg.sv -----
package ssrg_pkg;

    // Default tick rate of the time base, in ticks per second.
    localparam int TICK_HZ_DEFAULT = 100000;

    // Field widths.
    localparam int CMD_W      = 2;
    localparam int VEL_W      = 16;
    localparam int MAG_W      = 15;
    localparam int SPR_W      = 16;
    localparam int GEAR_W     = 16;
    localparam int AGE_W      = 24;
    localparam int PULSE_W    = 16;
    localparam int INTERVAL_W = 32;
    localparam int ELAPSED_W  = 32;
    localparam int DEN_W      = MAG_W + SPR_W;
    // Q2.14 velocity against Q8 gear: 2^14 / 2^8 leaves a factor of 64.
    localparam int GEAR_SHIFT = 6;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    // Stream payload widths, padded to whole bytes.
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    // Register reset values.
    localparam logic [SPR_W-1:0]   SPR_RESET     = 16'd200;
    localparam logic [GEAR_W-1:0]  GEAR_RESET    = 16'd256;
    localparam logic [AGE_W-1:0]   TIMEOUT_RESET = 24'd50000;
    localparam logic [PULSE_W-1:0] PULSE_RESET   = 16'd100;

    localparam logic signed [VEL_W-1:0] VEL_MAX = 16'sd16384;
    localparam logic signed [VEL_W-1:0] VEL_MIN = -16'sd16384;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_SET_VEL = 2'd1,
        CMD_SET_EN  = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_STEPS_PER_REV = 2'd0,
        CFG_GEAR_RATIO    = 2'd1,
        CFG_TIMEOUT       = 2'd2,
        CFG_PULSE_TICKS   = 2'd3
    } cfg_index_t;

    // Status of the interval divider toward the control logic.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- src/ssrg_serial_div.sv -----
// Step interval unit: forms TICK_HZ * gear * 64 and |v| * steps_per_rev and
// registers them on start, then divides them by restoring division, one
// quotient bit per cycle, with the numerator shifted out from its top bit.
module ssrg_serial_div #(
    parameter int TICK_HZ = ssrg_pkg::TICK_HZ_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [ssrg_pkg::MAG_W-1:0]        mag,
    input  logic [ssrg_pkg::SPR_W-1:0]        spr,
    input  logic [ssrg_pkg::GEAR_W-1:0]       gear,
    output logic [ssrg_pkg::INTERVAL_W-1:0]   interval,
    output ssrg_pkg::div_stat_t               stat
);
    import ssrg_pkg::*;

    localparam int HZ_W   = $clog2(TICK_HZ + 1);
    localparam int PROD_W = HZ_W + GEAR_W;
    localparam int NUM_W  = PROD_W + GEAR_SHIFT;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam logic [HZ_W-1:0] HZ_VAL = HZ_W'(TICK_HZ);

    typedef enum logic [2:0] {
        DIV_IDLE = 3'b001,
        DIV_RUN  = 3'b010,
        DIV_DONE = 3'b100
    } div_state_t;

    div_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [INTERVAL_W-1:0]   q_reg, q_next;
    logic                    ovf_reg, ovf_next;

    logic [PROD_W-1:0]       prod;
    logic [DEN_W:0]          rem_sh;
    logic [DEN_W:0]          rem_diff;
    logic                    fits;

    assign prod     = PROD_W'(HZ_VAL) * PROD_W'(gear);
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign fits     = rem_sh >= {1'b0, den_reg};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    num_next   = {prod, GEAR_SHIFT'(0)};
                    den_next   = DEN_W'(mag) * DEN_W'(spr);
                    rem_next   = '0;
                    q_next     = '0;
                    ovf_next   = 1'b0;
                    cnt_next   = CNT_W'(NUM_W);
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN: begin
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                rem_next = fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                q_next   = {q_reg[INTERVAL_W-2:0], fits};
                // Any quotient bit pushed past bit 31 means the result saturates.
                ovf_next = ovf_reg | q_reg[INTERVAL_W-1];
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE: begin
                state_next = DIV_IDLE;
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign interval  = ovf_reg ? '1 : q_reg;
    assign stat.busy = state_reg != DIV_IDLE;
    assign stat.done = state_reg == DIV_DONE;

endmodule

// ----- src/stepper_step_rate_generator.sv -----
// Stepper step/direction pulse generator.
// Input items arrive on the s_ stream: s_tuser carries the command (time tick,
// set velocity, set enable), s_tdata the velocity and the enable level. Every
// item yields exactly one result item on the m_ stream with the step, direction
// and enable pin levels, the step-started and timed-out flags and the current
// clamped velocity. Registers are written through cfg_wr_en/cfg_addr/cfg_wdata.
// Tick and set-enable items are handled in the cycle they are accepted; their
// result appears in the output register on the next cycle, so ticks can be
// accepted every cycle while the receiver keeps up and the divider is idle. A
// set-velocity item's result is registered the same way, but it also starts the
// step-interval divider, which latches its operands in the accept cycle, then
// shifts in one numerator bit per cycle (clog2(TICK_HZ+1)+22 bits, 39 at 100 kHz)
// and passes through a done state; s_tready stays low until the new interval is
// stored, so no new item is accepted while the divider works.
// Reset loads the register defaults, zero velocity, an all-ones interval,
// direction forward and enable high, and empties the output register.
// When the receiver stalls, the result is held in the output register and no
// new item is accepted until it has been taken or is taken in the same cycle.
`include "stepper_step_rate_generator_assert.svh"

module stepper_step_rate_generator #(
    parameter int TICK_HZ = ssrg_pkg::TICK_HZ_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port.
    input  logic                               cfg_wr_en,
    input  logic [ssrg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ssrg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Input item stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: velocity [15:0], enable_value [16], zero [23:17]
    input  logic [ssrg_pkg::S_DATA_W-1:0]      s_tdata,
    // s_tuser: cmd [1:0]
    input  logic [ssrg_pkg::CMD_W-1:0]         s_tuser,
    // Result item stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: step_pin [0], dir_pin [1], enable_pin [2], step_taken [3],
    //          velocity_now [19:4], timed_out [20], zero [23:21]
    output logic [ssrg_pkg::M_DATA_W-1:0]      m_tdata
);
    import ssrg_pkg::*;

    localparam int M_USED_W = VEL_W + 5;

    // Configuration registers.
    logic [SPR_W-1:0]         spr_reg;
    logic [GEAR_W-1:0]        gear_reg;
    logic [AGE_W-1:0]         timeout_reg;
    logic [PULSE_W-1:0]       pulse_ticks_reg;

    // Motion state.
    logic signed [VEL_W-1:0]  vel_reg, vel_next;
    logic [INTERVAL_W-1:0]    interval_reg, interval_next;
    logic [ELAPSED_W-1:0]     elapsed_reg, elapsed_next;
    logic [AGE_W-1:0]         age_reg, age_next;
    logic [PULSE_W-1:0]       pulse_reg, pulse_next;
    logic                     dir_reg, dir_next;
    logic                     en_reg, en_next;

    // Output register.
    logic                     m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]      m_data_reg;

    logic                     accept;
    cmd_t                     cmd;
    logic signed [VEL_W-1:0]  vel_in;
    logic signed [VEL_W-1:0]  vel_clamped;
    logic signed [VEL_W-1:0]  vel_neg;
    logic [MAG_W-1:0]         vel_mag;
    logic [AGE_W-1:0]         age_inc;
    logic [ELAPSED_W-1:0]     elapsed_inc;
    logic                     step_taken;
    logic                     timed_out;
    logic                     div_start;
    logic [INTERVAL_W-1:0]    div_interval;
    div_stat_t                div_stat;

    // The divider holds off new items until the interval it computes is stored.
    assign s_tready = !div_stat.busy && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);

    // Clamp the commanded velocity to plus or minus 1.0 in Q2.14.
    assign vel_in = s_tdata[VEL_W-1:0];
    always_comb begin
        if (vel_in > VEL_MAX) begin
            vel_clamped = VEL_MAX;
        end else if (vel_in < VEL_MIN) begin
            vel_clamped = VEL_MIN;
        end else begin
            vel_clamped = vel_in;
        end
    end
    assign vel_neg = -vel_clamped;
    assign vel_mag = vel_clamped[VEL_W-1] ? vel_neg[MAG_W-1:0] : vel_clamped[MAG_W-1:0];

    // Saturating counters of the tick path.
    assign age_inc     = (age_reg == '1) ? age_reg : age_reg + AGE_W'(1);
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + ELAPSED_W'(1);

    always_comb begin
        vel_next      = vel_reg;
        interval_next = interval_reg;
        elapsed_next  = elapsed_reg;
        age_next      = age_reg;
        pulse_next    = pulse_reg;
        dir_next      = dir_reg;
        en_next       = en_reg;
        step_taken    = 1'b0;
        timed_out     = 1'b0;
        div_start     = 1'b0;

        if (div_stat.done) begin
            interval_next = div_interval;
        end

        if (accept) begin
            unique case (cmd)
                CMD_TICK: begin
                    // The command ages first; a stale command stops the motor.
                    age_next = age_inc;
                    if (age_inc > timeout_reg) begin
                        timed_out = vel_reg != '0;
                        vel_next  = '0;
                    end
                    elapsed_next = elapsed_inc;
                    // A running pulse only counts down; a new step waits for it.
                    if (pulse_reg != '0) begin
                        pulse_next = pulse_reg - PULSE_W'(1);
                    end else if (vel_next != '0 && elapsed_inc > interval_reg) begin
                        pulse_next   = pulse_ticks_reg;
                        elapsed_next = '0;
                        step_taken   = 1'b1;
                    end
                end
                CMD_SET_VEL: begin
                    vel_next  = vel_clamped;
                    age_next  = '0;
                    div_start = 1'b1;
                    // A zero command keeps the last direction.
                    if (vel_clamped > 0) begin
                        dir_next = 1'b1;
                    end else if (vel_clamped < 0) begin
                        dir_next = 1'b0;
                    end
                end
                CMD_SET_EN: begin
                    en_next = s_tdata[VEL_W];
                end
                default: begin
                end
            endcase
        end

        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    ssrg_serial_div #(
        .TICK_HZ (TICK_HZ)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .mag      (vel_mag),
        .spr      (spr_reg),
        .gear     (gear_reg),
        .interval (div_interval),
        .stat     (div_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spr_reg         <= SPR_RESET;
            gear_reg        <= GEAR_RESET;
            timeout_reg     <= TIMEOUT_RESET;
            pulse_ticks_reg <= PULSE_RESET;
            vel_reg         <= '0;
            interval_reg    <= '1;
            elapsed_reg     <= '0;
            age_reg         <= '0;
            pulse_reg       <= '0;
            dir_reg         <= 1'b1;
            en_reg          <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index_t'(cfg_addr))
                    CFG_STEPS_PER_REV: spr_reg         <= cfg_wdata[SPR_W-1:0];
                    CFG_GEAR_RATIO:    gear_reg        <= cfg_wdata[GEAR_W-1:0];
                    CFG_TIMEOUT:       timeout_reg     <= cfg_wdata[AGE_W-1:0];
                    CFG_PULSE_TICKS:   pulse_ticks_reg <= cfg_wdata[PULSE_W-1:0];
                    default: begin
                    end
                endcase
            end
            vel_reg      <= vel_next;
            interval_reg <= interval_next;
            elapsed_reg  <= elapsed_next;
            age_reg      <= age_next;
            pulse_reg    <= pulse_next;
            dir_reg      <= dir_next;
            en_reg       <= en_next;
            m_valid_reg  <= m_valid_next;
        end
        if (accept) begin
            m_data_reg <= {(M_DATA_W - M_USED_W)'(0), timed_out, vel_next, step_taken,
                           en_next, dir_next, pulse_next == '0};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A set-velocity item must hand its work to the divider.
    `SSRG_ASSERT_NEXT(a_set_vel_starts_div, aclk, aresetn,
        accept && cmd == CMD_SET_VEL, div_stat.busy, "set velocity did not start the divider")
    // The divider reports completion for exactly one cycle.
    `SSRG_ASSERT_NEXT(a_div_done_single, aclk, aresetn,
        div_stat.done, !div_stat.done, "divider done held for more than one cycle")
    // The stored velocity never leaves the clamp range.
    `SSRG_ASSERT_NOW(a_vel_in_range, aclk, aresetn,
        1'b1, vel_reg <= VEL_MAX && vel_reg >= VEL_MIN, "stored velocity out of range")

endmodule
